>>> sv/skeleton_endpoint_detector_macros.svh
// Assertion helpers, clocked on clk, held off during reset.
`ifndef SKELETON_ENDPOINT_DETECTOR_MACROS_SVH
`define SKELETON_ENDPOINT_DETECTOR_MACROS_SVH

// same-cycle implication
`define SED_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/sed_pkg.sv
package sed_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int MIN_SIZE       = 3;

	localparam int PIX_W      = 8;
	localparam int COL_W      = 11;
	localparam int ROW_W      = 12;
	localparam int CODE_W     = 8;
	localparam int CFG_WID_W  = 12;
	localparam int CFG_HGT_W  = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = 13'd480;

	typedef struct packed {
		logic [COL_W-1:0]  end_column;
		logic [ROW_W-1:0]  end_row;
		logic [CODE_W-1:0] neighbour_code;
	} result_t;

endpackage

>>> sv/sed_pixel_if.sv
interface sed_pixel_if;
	logic                      valid;
	logic                      ready;
	logic [sed_pkg::PIX_W-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

>>> sv/sed_endpoint_if.sv
interface sed_endpoint_if;
	logic                       valid;
	logic                       ready;
	logic [sed_pkg::COL_W-1:0]  end_column;
	logic [sed_pkg::ROW_W-1:0]  end_row;
	logic [sed_pkg::CODE_W-1:0] neighbour_code;

	modport source (output valid, output end_column, output end_row, output neighbour_code,
		input ready);
	modport sink (input valid, input end_column, input end_row, input neighbour_code,
		output ready);
endinterface

>>> sv/sed_cfg_if.sv
interface sed_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sed_pkg::CFG_IDX_W-1:0]  index;
	logic [sed_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/sed_front.sv
module sed_front #(
	parameter int MAX_WIDTH  = sed_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sed_pkg::MAX_HEIGHT_DEF,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sed_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [sed_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            accept,
	input  logic [sed_pkg::PIX_W-1:0]       pixel_value,
	output logic [CW-1:0]                   col,
	output logic                            v_s1,
	output logic                            occ_s1,
	output logic [CW-1:0]                   col_s1,
	output logic [RW-1:0]                   row_s1
);

	localparam int WL = CW + 1;
	localparam int HL = RW + 1;

	logic [sed_pkg::CFG_WID_W-1:0] width_q;
	logic [sed_pkg::CFG_HGT_W-1:0] height_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WL-1:0] w_eff, col_inc;
	logic [HL-1:0] h_eff, row_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sed_pkg::WIDTH_RESET;
			height_q <= sed_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				sed_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[sed_pkg::CFG_WID_W-1:0];
				end
				sed_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[sed_pkg::CFG_HGT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// saturate frame size to [3, max]
	always_comb begin
		if (width_q < sed_pkg::CFG_WID_W'(sed_pkg::MIN_SIZE))
			w_eff = WL'(sed_pkg::MIN_SIZE);
		else if (32'(width_q) > 32'(MAX_WIDTH))
			w_eff = WL'(MAX_WIDTH);
		else
			w_eff = WL'(width_q);
		if (height_q < sed_pkg::CFG_HGT_W'(sed_pkg::MIN_SIZE))
			h_eff = HL'(sed_pkg::MIN_SIZE);
		else if (32'(height_q) > 32'(MAX_HEIGHT))
			h_eff = HL'(MAX_HEIGHT);
		else
			h_eff = HL'(height_q);
	end

	assign col_inc = {1'b0, col_q} + WL'(1);
	assign row_inc = {1'b0, row_q} + HL'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				if (col_inc >= w_eff) begin
					col_q <= '0;
					if (row_inc >= h_eff)
						row_q <= '0;
					else
						row_q <= row_inc[RW-1:0];
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			occ_s1 <= (pixel_value == '0);
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	assign col = col_q;

endmodule

>>> sv/sed_line_buf.sv
module sed_line_buf #(
	parameter int MAX_WIDTH = sed_pkg::MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [CW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [CW-1:0] wr_addr,
	input  logic          wr_occ,
	output logic          top,
	output logic          mid
);

	logic upper_mem [MAX_WIDTH];
	logic middle_mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			top <= upper_mem[rd_addr];
			mid <= middle_mem[rd_addr];
		end
	end

	// rows shift down one line store as the current row is written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr]  <= mid;
			middle_mem[wr_addr] <= wr_occ;
		end
	end

endmodule

>>> sv/sed_window.sv
module sed_window #(
	parameter int MAX_WIDTH  = sed_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sed_pkg::MAX_HEIGHT_DEF,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             top,
	input  logic             mid,
	input  logic             occ,
	input  logic [CW-1:0]    col,
	input  logic [RW-1:0]    row,
	output logic             hit,
	output sed_pkg::result_t res
);

	logic [8:0] win_q, win_nxt;
	logic [sed_pkg::CODE_W-1:0] code;
	logic [CW-1:0] col_dec;
	logic [RW-1:0] row_dec;

	// column c in bits 2:0, c-1 in 5:3, c-2 in 8:6; top row in the low bit
	assign win_nxt = {win_q[5:0], occ, mid, top};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= '0;
		else if (step)
			win_q <= win_nxt;
	end

	// bit 7 north, then counterclockwise from northwest down to northeast in bit 0
	assign code = {win_nxt[3], win_nxt[6], win_nxt[7], win_nxt[8],
		win_nxt[5], win_nxt[2], win_nxt[1], win_nxt[0]};

	assign col_dec = col - CW'(1);
	assign row_dec = row - RW'(1);

	assign hit = step && (col >= CW'(2)) && (row >= RW'(2)) && win_nxt[4] && $onehot(code);

	always_comb begin
		res.end_column     = sed_pkg::COL_W'(col_dec);
		res.end_row        = sed_pkg::ROW_W'(row_dec);
		res.neighbour_code = code;
	end

endmodule

>>> sv/sed_out_buf.sv
module sed_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sed_pkg::result_t      push_data,
	output logic [1:0]            cnt,
	sed_endpoint_if.source        endp
);

	sed_pkg::result_t ent_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic pop;

	assign pop = endp.valid && endp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_data;
	end

	assign cnt                 = cnt_q;
	assign endp.valid          = (cnt_q != 2'd0);
	assign endp.end_column     = ent_q[rd_ptr_q].end_column;
	assign endp.end_row        = ent_q[rd_ptr_q].end_row;
	assign endp.neighbour_code = ent_q[rd_ptr_q].neighbour_code;

endmodule

>>> sv/skeleton_endpoint_detector.sv
// channel  role    payload                                   beat
// pix      sink    pixel_value[7:0]                          one raster pixel
// endp     source  end_column[10:0] end_row[11:0] code[7:0]  one endpoint
// cfg      sink    index[0] data[12:0]                       one register write
//
// One pixel per cycle while pix.ready is high; after its pixel beat a result passes the
// line store read, then window update and test into the two-entry output queue.
// arst_n clears counters, window and queue; size registers return to 640 x 480.
// The line stores are not cleared. pix.ready drops whenever the output queue could
// overflow under endp stalls, counting the in-flight beat; cfg is always ready.
module skeleton_endpoint_detector #(
	parameter int MAX_WIDTH  = sed_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sed_pkg::MAX_HEIGHT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	sed_pixel_if.sink       pix,
	sed_endpoint_if.source  endp,
	sed_cfg_if.sink         cfg
);

	`include "skeleton_endpoint_detector_macros.svh"

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic accept, v_s1, occ_s1, top, mid, hit, pop;
	logic [CW-1:0] col, col_s1;
	logic [RW-1:0] row_s1;
	logic [1:0] out_cnt;
	logic [2:0] pending;
	sed_pkg::result_t res;

	assign cfg.ready = 1'b1;
	assign accept    = pix.valid && pix.ready;
	assign pop       = endp.valid && endp.ready;
	assign pending   = 3'(out_cnt) + 3'(v_s1);
	assign pix.ready = (pending <= 3'd1) || (pop && pending == 3'd2);

	sed_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid && cfg.ready),
		.cfg_idx     (cfg.index),
		.cfg_data    (cfg.data),
		.accept      (accept),
		.pixel_value (pix.pixel_value),
		.col         (col),
		.v_s1        (v_s1),
		.occ_s1      (occ_s1),
		.col_s1      (col_s1),
		.row_s1      (row_s1)
	);

	sed_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.wr_en   (v_s1),
		.wr_addr (col_s1),
		.wr_occ  (occ_s1),
		.top     (top),
		.mid     (mid)
	);

	sed_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (v_s1),
		.top    (top),
		.mid    (mid),
		.occ    (occ_s1),
		.col    (col_s1),
		.row    (row_s1),
		.hit    (hit),
		.res    (res)
	);

	sed_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (hit),
		.push_data (res),
		.cnt       (out_cnt),
		.endp      (endp)
	);

	`SED_ASSERT_NOW(a_no_overflow, v_s1, out_cnt != 2'd2 || pop, "output queue overflow")
	`SED_ASSERT_NEXT(a_stage_follows, accept, v_s1, "pixel beat lost before window stage")
	`SED_ASSERT_NOW(a_code_onehot, endp.valid, $onehot(endp.neighbour_code), "code not one-hot")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import sed_pkg::*;

	localparam int WIDTH_LIMIT   = MAX_WIDTH_DEF;
	localparam int HEIGHT_LIMIT  = MAX_HEIGHT_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_ITEMS  = 500;

	logic clk;
	logic arst_n;

	sed_pixel_if    pix_bus ();
	sed_endpoint_if endp_bus ();
	sed_cfg_if      cfg_bus ();

	skeleton_endpoint_detector dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pix   (pix_bus),
		.endp  (endp_bus),
		.cfg   (cfg_bus)
	);

	// occupancy of the two rows above, 3x3 window, raster position
	bit                   upper_occ [WIDTH_LIMIT];
	bit                   middle_occ [WIDTH_LIMIT];
	// columns whose line store entries hold written data
	bit                   upper_set [WIDTH_LIMIT];
	bit                   middle_set [WIDTH_LIMIT];
	logic [8:0]           window_occ = '0;
	int unsigned          column_pos = 0;
	int unsigned          row_pos = 0;
	logic [CFG_WID_W-1:0] width_reg = WIDTH_RESET;
	logic [CFG_HGT_W-1:0] height_reg = HEIGHT_RESET;

	result_t          pending_endpoints[$];
	logic [PIX_W-1:0] pixel_feed[$];

	int errors = 0;
	int pixel_beats = 0;
	int endpoint_beats = 0;
	int reg_writes = 0;
	bit pix_fire = 0;
	bit rx_hold = 0;
	bit pressure_go = 0;
	bit no_idle = 0;
	int pix_gap = 0;
	int rx_gap = 0;
	int tx_idle_pct = 10;
	int rx_idle_pct = 10;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		wait (pressure_go);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	function automatic int unsigned effective_size(int unsigned raw, int unsigned hi);
		if (raw < MIN_SIZE)
			return MIN_SIZE;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	function automatic bit columns_held(int unsigned w);
		for (int unsigned i = 0; i < w; i++)
			if (!upper_set[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void track_pixel(logic [PIX_W-1:0] px);
		int unsigned       w;
		int unsigned       h;
		bit                occ;
		logic [CODE_W-1:0] code;
		result_t           hit;
		w = effective_size(32'(width_reg), WIDTH_LIMIT);
		h = effective_size(32'(height_reg), HEIGHT_LIMIT);
		occ = (px == '0);
		window_occ = {window_occ[5:0], occ, middle_occ[column_pos], upper_occ[column_pos]};
		if (column_pos >= 2 && row_pos >= 2 && window_occ[4]) begin
			// N, NW, W, SW, S, SE, E, NE from bit 7 down
			code = {window_occ[3], window_occ[6], window_occ[7], window_occ[8],
				window_occ[5], window_occ[2], window_occ[1], window_occ[0]};
			if ($onehot(code)) begin
				hit.end_column     = COL_W'(column_pos - 1);
				hit.end_row        = ROW_W'(row_pos - 1);
				hit.neighbour_code = code;
				pending_endpoints = {pending_endpoints, hit};
			end
		end
		upper_occ[column_pos]  = middle_occ[column_pos];
		middle_occ[column_pos] = occ;
		upper_set[column_pos]  = middle_set[column_pos];
		middle_set[column_pos] = 1'b1;
		if (column_pos + 1 >= w) begin
			column_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			column_pos++;
		end
	endfunction

	function automatic int pixels_left_in_frame();
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		int          n;
		w = effective_size(32'(width_reg), WIDTH_LIMIT);
		h = effective_size(32'(height_reg), HEIGHT_LIMIT);
		c = column_pos;
		r = row_pos;
		n = 0;
		if (c == 0 && r == 0)
			return 0;
		do begin
			n++;
			if (c + 1 >= w) begin
				c = 0;
				r = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				c++;
			end
		end while (c != 0 || r != 0);
		return n;
	endfunction

	task automatic queue_pixels(input int count, input int density_pct);
		repeat (count) begin
			if ($urandom_range(0, 99) < density_pct)
				pixel_feed = {pixel_feed, PIX_W'(0)};
			else
				pixel_feed = {pixel_feed, PIX_W'($urandom_range(1, 255))};
		end
	endtask

	// occupied pairs on even rows, every pair pixel is an endpoint
	task automatic queue_pairs(input int count);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		w = effective_size(32'(width_reg), WIDTH_LIMIT);
		h = effective_size(32'(height_reg), HEIGHT_LIMIT);
		c = column_pos;
		r = row_pos;
		repeat (count) begin
			if (r[0] == 1'b0 && c[1] == 1'b0)
				pixel_feed = {pixel_feed, PIX_W'(0)};
			else
				pixel_feed = {pixel_feed, PIX_W'(255)};
			if (c + 1 >= w) begin
				c = 0;
				r = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				c++;
			end
		end
	endtask

	task automatic wait_idle();
		while (pixel_feed.size() != 0 || pix_bus.valid || pending_endpoints.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// widening mid-frame onto columns the stores never held: cut the frame short, finish it
	task automatic resize(input bit set_w, input logic [CFG_DATA_W-1:0] w_data,
		input bit set_h, input logic [CFG_DATA_W-1:0] h_data);
		int          fill;
		int unsigned new_w;
		wait_idle();
		new_w = effective_size(32'(w_data[CFG_WID_W-1:0]), WIDTH_LIMIT);
		if (set_w && new_w > effective_size(32'(width_reg), WIDTH_LIMIT) &&
			!columns_held(new_w)) begin
			fill = pixels_left_in_frame();
			if (fill > 0) begin
				write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(MIN_SIZE));
				fill = pixels_left_in_frame();
				queue_pixels(fill, 20);
				wait_idle();
			end
		end
		if (set_w)
			write_reg(REG_IMAGE_WIDTH, w_data);
		if (set_h)
			write_reg(REG_IMAGE_HEIGHT, h_data);
	endtask

	always @(posedge clk) begin : watch
		result_t want;
		pix_fire = arst_n && pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1;
		if (arst_n && endp_bus.valid === 1'b1 && endp_bus.ready === 1'b1) begin
			endpoint_beats++;
			if (pending_endpoints.size() == 0) begin
				flag_mismatch($sformatf("unexpected endpoint col %0d row %0d code %h",
					endp_bus.end_column, endp_bus.end_row, endp_bus.neighbour_code));
			end else begin
				want = pending_endpoints.pop_front();
				if (endp_bus.end_column !== want.end_column)
					flag_mismatch($sformatf("end_column %0d, want %0d",
						endp_bus.end_column, want.end_column));
				if (endp_bus.end_row !== want.end_row)
					flag_mismatch($sformatf("end_row %0d, want %0d",
						endp_bus.end_row, want.end_row));
				if (endp_bus.neighbour_code !== want.neighbour_code)
					flag_mismatch($sformatf("neighbour_code %h, want %h at col %0d row %0d",
						endp_bus.neighbour_code, want.neighbour_code,
						want.end_column, want.end_row));
			end
		end
		if (pix_fire) begin
			pixel_beats++;
			track_pixel(pix_bus.pixel_value);
		end
		if (arst_n && cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1) begin
			reg_writes++;
			case (cfg_bus.index)
				REG_IMAGE_WIDTH: width_reg = cfg_bus.data[CFG_WID_W-1:0];
				REG_IMAGE_HEIGHT: height_reg = cfg_bus.data;
				default: ;
			endcase
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (pix_bus.valid !== 1'b1 || pix_fire) begin
				if (pix_gap > 0) begin
					pix_gap--;
					pix_bus.valid <= 1'b0;
				end else if (pix_fire && !no_idle && $urandom_range(0, 99) < tx_idle_pct) begin
					pix_gap = $urandom_range(0, 10);
					pix_bus.valid <= 1'b0;
				end else if (pixel_feed.size() != 0) begin
					pix_bus.valid       <= 1'b1;
					pix_bus.pixel_value <= pixel_feed.pop_front();
				end else begin
					pix_bus.valid <= 1'b0;
				end
			end
			if (rx_hold) begin
				endp_bus.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				endp_bus.ready <= 1'b0;
			end else if (endp_bus.ready && !no_idle && $urandom_range(0, 99) < rx_idle_pct) begin
				rx_gap = $urandom_range(0, 10);
				endp_bus.ready <= 1'b0;
			end else begin
				endp_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [PIX_W-1:0]      directed_px [27];
		int                    density_menu [5];
		int                    idle_menu [4];
		logic [CFG_DATA_W-1:0] wd;
		logic [CFG_DATA_W-1:0] hd;
		int                    random_items;
		int                    n;
		int                    pick;

		// north neighbour only, southwest only, fully surrounded (3x3 frames)
		directed_px = '{200, 0, 255, 1, 0, 128, 255, 127, 254,
			255, 255, 255, 64, 0, 32, 0, 16, 8,
			0, 0, 0, 0, 0, 0, 0, 0, 0};
		density_menu = '{5, 12, 20, 30, 45};
		idle_menu = '{0, 8, 20, 35};

		arst_n              = 1'b0;
		pix_bus.valid       = 1'b0;
		pix_bus.pixel_value = '0;
		endp_bus.ready      = 1'b0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.index       = REG_IMAGE_WIDTH;
		cfg_bus.data        = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sizes below the minimum saturate to 3x3
		resize(1'b1, 13'd0, 1'b1, 13'd2);
		foreach (directed_px[i])
			pixel_feed = {pixel_feed, directed_px[i]};

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick < 15)
				wd = CFG_DATA_W'($urandom_range(3, 24));
			else if (pick < 17)
				wd = CFG_DATA_W'($urandom_range(0, 2));
			else
				wd = 13'h1000 | CFG_DATA_W'($urandom_range(3, 24));
			pick = $urandom_range(0, 19);
			if (pick < 14)
				hd = CFG_DATA_W'($urandom_range(3, 12));
			else if (pick < 17)
				hd = CFG_DATA_W'($urandom_range(0, 2));
			else
				hd = CFG_DATA_W'($urandom_range(4097, 8191));
			resize(1'($urandom_range(0, 1)), wd, 1'($urandom_range(0, 1)), hd);
			tx_idle_pct = idle_menu[$urandom_range(0, 3)];
			rx_idle_pct = idle_menu[$urandom_range(0, 3)];
			n = $urandom_range(12, 80);
			queue_pixels(n, density_menu[$urandom_range(0, 4)]);
			random_items += n;
		end

		// long output stall with the source still pushing endpoint-rich rows
		resize(1'b1, 13'd16, 1'b1, 13'd8);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		pressure_go = 1'b1;
		queue_pairs(128);

		// widest rows (4095 saturates), then top height code (high bit masked off the width)
		resize(1'b1, 13'h0FFF, 1'b1, 13'd3);
		tx_idle_pct = 8;
		rx_idle_pct = 8;
		queue_pixels(60, 15);
		resize(1'b1, 13'h1003, 1'b1, 13'h1FFF);
		queue_pixels(40, 25);

		resize(1'b1, 13'd12, 1'b1, 13'd7);
		no_idle = 1'b1;
		queue_pixels(80, 20);
		wait_idle();

		$display("%0d pixel beats, %0d endpoint beats, %0d register writes checked",
			pixel_beats, endpoint_beats, reg_writes);
		$display("saturated and random frame sizes, mid-frame resizes, short and long stalls");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
